// ===== hdl/cfsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cfsc_pkg;
    localparam int CompBits = 16;
    localparam int FracBits = 15;
    localparam int MagW     = CompBits + 1;
    localparam int RemW     = CompBits + 1;
    localparam int CoordW   = FracBits + 1;

    typedef logic [2:0] t_face;
    localparam t_face FACE_PX = 3'd0;
    localparam t_face FACE_NX = 3'd1;
    localparam t_face FACE_PY = 3'd2;
    localparam t_face FACE_NY = 3'd3;
    localparam t_face FACE_PZ = 3'd4;
    localparam t_face FACE_NZ = 3'd5;

    // setup for one coordinate divider lane
    typedef struct packed {
        logic                dodiv;
        logic                one;
        logic [RemW-1:0]     num;
        logic [CompBits-1:0] den;
    } t_lane;
endpackage
`default_nettype wire

// ===== hdl/cfsc_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
module cfsc_div_lane (
    input  wire logic                        i_clk,
    input  wire cfsc_pkg::t_lane             i_lane,
    output logic [cfsc_pkg::CoordW-1:0]      o_coord
);
    localparam int F = cfsc_pkg::FracBits;
    localparam int R = cfsc_pkg::RemW;
    localparam int C = cfsc_pkg::CompBits;

    logic [R-1:0] r_rem  [1:F-1];
    logic [F-1:0] r_q    [1:F];
    logic [C-1:0] r_den  [1:F-1];
    logic         r_div  [1:F];
    logic         r_one  [1:F];

    for (genvar k = 0; k < F; k++) begin : g_stage
        logic [R-1:0] p_rem;
        logic [F-1:0] p_q;
        logic [C-1:0] p_den;
        logic         p_div;
        logic         p_one;
        logic         n_bit;

        // stage inputs: the lane setup feeds the first stage
        if (k == 0) begin : g_first
            assign p_rem = i_lane.num;
            assign p_q   = '0;
            assign p_den = i_lane.den;
            assign p_div = i_lane.dodiv;
            assign p_one = i_lane.one;
        end else begin : g_next
            assign p_rem = r_rem[k];
            assign p_q   = r_q[k];
            assign p_den = r_den[k];
            assign p_div = r_div[k];
            assign p_one = r_one[k];
        end

        // one quotient bit
        always_comb begin
            n_bit = p_rem >= {1'b0, p_den};
        end

        always_ff @(posedge i_clk) begin
            r_q[k+1]   <= {p_q[F-2:0], n_bit};
            r_div[k+1] <= p_div;
            r_one[k+1] <= p_one;
        end

        // partial remainder for the next stage
        if (k < F - 1) begin : g_carry
            logic [R-1:0] n_sub;
            always_comb begin
                n_sub = n_bit ? (p_rem - {1'b0, p_den}) : p_rem;
            end
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= {n_sub[R-2:0], 1'b0};
                r_den[k+1] <= p_den;
            end
        end
    end

    // constant ends or the quotient
    always_comb begin
        if (r_div[F]) begin
            o_coord = {1'b0, r_q[F]};
        end else begin
            o_coord = {r_one[F], {F{1'b0}}};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/cube_face_select_and_coords.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Cube-map face selection and face coordinates. A direction is taken with
// start whenever busy is low; busy never rises, so one direction per cycle
// is accepted. The accepting edge loads the first setup stage; the result
// then passes the second setup stage and one divider stage per fraction
// bit and is on the outputs for one cycle with o_valid high; the
// receiver cannot stall, so results must be taken as they come.
module cube_face_select_and_coords (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [cfsc_pkg::CompBits-1:0] i_vec_x,
    input  wire logic signed [cfsc_pkg::CompBits-1:0] i_vec_y,
    input  wire logic signed [cfsc_pkg::CompBits-1:0] i_vec_z,
    input  wire logic                                i_face_auto,
    input  wire logic [2:0]                          i_face_sel,
    output logic                                     o_valid,
    output logic [2:0]                               o_face,
    output logic [cfsc_pkg::CoordW-1:0]              o_coord_u,
    output logic [cfsc_pkg::CoordW-1:0]              o_coord_v
);
    localparam int C = cfsc_pkg::CompBits;
    localparam int M = cfsc_pkg::MagW;
    localparam int R = cfsc_pkg::RemW;
    localparam int F = cfsc_pkg::FracBits;

    assign busy = 1'b0;

    function automatic logic [M-1:0] mag_of(input logic signed [C-1:0] v);
        logic signed [M-1:0] w;
        w = M'(v);
        return w[M-1] ? M'(-w) : M'(w);
    endfunction

    // stage 1: magnitudes and face choice
    logic [M-1:0]      n_ax, n_ay, n_az;
    cfsc_pkg::t_face   n_face;
    always_comb begin
        n_ax = mag_of(i_vec_x);
        n_ay = mag_of(i_vec_y);
        n_az = mag_of(i_vec_z);
        if (!i_face_auto && i_face_sel <= cfsc_pkg::FACE_NZ) begin
            n_face = i_face_sel;
        end else if (n_ax > n_ay && n_ax > n_az) begin
            n_face = (i_vec_x > 0) ? cfsc_pkg::FACE_PX : cfsc_pkg::FACE_NX;
        end else if (n_ay > n_ax && n_ay > n_az) begin
            n_face = (i_vec_y > 0) ? cfsc_pkg::FACE_PY : cfsc_pkg::FACE_NY;
        end else begin
            n_face = (i_vec_z > 0) ? cfsc_pkg::FACE_PZ : cfsc_pkg::FACE_NZ;
        end
    end

    logic                    r_v1;
    logic signed [C-1:0]     r_x, r_y, r_z;
    cfsc_pkg::t_face         r_face1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
        end
        r_x     <= i_vec_x;
        r_y     <= i_vec_y;
        r_z     <= i_vec_z;
        r_face1 <= n_face;
    end

    // stage 2: pick axes per face and set up both lanes
    logic signed [C-1:0] n_mj, n_mu, n_mv;
    logic                n_su, n_sv;
    logic [M-1:0]        n_a, n_amu, n_amv;
    logic                n_opp;
    cfsc_pkg::t_lane     n_lu, n_lv;

    function automatic cfsc_pkg::t_lane setup(input logic signed [C-1:0] m,
                                              input logic neg,
                                              input logic [M-1:0] a,
                                              input logic [M-1:0] am);
        cfsc_pkg::t_lane     l;
        logic signed [R:0]   sm;
        logic signed [R:0]   sum;
        sm  = neg ? -(R+1)'(m) : (R+1)'(m);
        sum = sm + $signed({1'b0, R'(a)});
        l.dodiv = a > am;
        l.one   = (m > 0) ^ neg;
        l.num   = sum[R-1:0];
        l.den   = a[C-1:0];
        return l;
    endfunction

    always_comb begin
        unique case (r_face1)
            cfsc_pkg::FACE_PX: begin
                n_mj = r_x; n_mu = r_z; n_mv = r_y; n_su = 1'b1; n_sv = 1'b1;
            end
            cfsc_pkg::FACE_NX: begin
                n_mj = r_x; n_mu = r_z; n_mv = r_y; n_su = 1'b0; n_sv = 1'b1;
            end
            cfsc_pkg::FACE_PY: begin
                n_mj = r_y; n_mu = r_x; n_mv = r_z; n_su = 1'b0; n_sv = 1'b0;
            end
            cfsc_pkg::FACE_NY: begin
                n_mj = r_y; n_mu = r_x; n_mv = r_z; n_su = 1'b0; n_sv = 1'b1;
            end
            cfsc_pkg::FACE_PZ: begin
                n_mj = r_z; n_mu = r_x; n_mv = r_y; n_su = 1'b0; n_sv = 1'b1;
            end
            default: begin
                n_mj = r_z; n_mu = r_x; n_mv = r_y; n_su = 1'b1; n_sv = 1'b1;
            end
        endcase
        n_a   = mag_of(n_mj);
        n_amu = mag_of(n_mu);
        n_amv = mag_of(n_mv);
        n_lu  = setup(n_mu, n_su, n_a, n_amu);
        n_lv  = setup(n_mv, n_sv, n_a, n_amv);
        // major component points away from the face: push to nearer edge
        n_opp = (r_face1[0] ? (n_mj > 0) : (n_mj < 0)) && n_a > n_amu && n_a > n_amv;
        if (n_opp) begin
            if (n_amu > n_amv) begin
                n_lu.dodiv = 1'b0;
                n_lu.one   = (n_mu != 0) && ((n_mu > 0) ^ n_su);
            end else begin
                n_lv.dodiv = 1'b0;
                n_lv.one   = (n_mv != 0) && ((n_mv > 0) ^ n_sv);
            end
        end
    end

    logic            r_v2;
    cfsc_pkg::t_face r_face2;
    cfsc_pkg::t_lane r_lu, r_lv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_face2 <= r_face1;
        r_lu    <= n_lu;
        r_lv    <= n_lv;
    end

    // divider lanes
    cfsc_div_lane u_lane_u (.i_clk(i_clk), .i_lane(r_lu), .o_coord(o_coord_u));
    cfsc_div_lane u_lane_v (.i_clk(i_clk), .i_lane(r_lv), .o_coord(o_coord_v));

    // valid and face travel alongside the lanes
    logic            r_vp [0:F-1];
    cfsc_pkg::t_face r_fp [0:F-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < F; k++) r_vp[k] <= 1'b0;
        end else begin
            r_vp[0] <= r_v2;
            for (int k = 1; k < F; k++) r_vp[k] <= r_vp[k-1];
        end
        r_fp[0] <= r_face2;
        for (int k = 1; k < F; k++) r_fp[k] <= r_fp[k-1];
    end

    assign o_valid = r_vp[F-1];
    assign o_face  = r_fp[F-1];

    // checks
    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coord_u <= {1'b1, {F{1'b0}}}) && (o_coord_v <= {1'b1, {F{1'b0}}}))
        else $error("coordinate above one");
    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_face <= cfsc_pkg::FACE_NZ)
        else $error("face code out of range");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ##(F) o_valid)
        else $error("transaction lost in pipeline");
endmodule
`default_nettype wire

// ===== tb/sv/cube_face_select_and_coords_tb.sv =====
`timescale 1ns / 1ps
module cube_face_select_and_coords_tb;
    localparam int WatchLimit = 2000;
    localparam int Latency    = 17;
    localparam int CompBits   = cfsc_pkg::CompBits;
    localparam int FracBits   = cfsc_pkg::FracBits;
    localparam int CoordW     = cfsc_pkg::CoordW;

    typedef struct {
        cfsc_pkg::t_face   face;
        logic [CoordW-1:0] u;
        logic [CoordW-1:0] v;
    } t_coord_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [CompBits-1:0] i_vec_x = '0;
    logic signed [CompBits-1:0] i_vec_y = '0;
    logic signed [CompBits-1:0] i_vec_z = '0;
    logic                       i_face_auto = 1'b0;
    logic [2:0]                 i_face_sel = '0;
    logic                       o_valid;
    logic [2:0]                 o_face;
    logic [CoordW-1:0]          o_coord_u;
    logic [CoordW-1:0]          o_coord_v;

    t_coord_result pending_coords[$];
    int            n_errors = 0;
    int            idle_pct = 0;
    int            quiet_cycles = 0;

    cube_face_select_and_coords u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .i_face_auto (i_face_auto),
        .i_face_sel  (i_face_sel),
        .o_valid     (o_valid),
        .o_face      (o_face),
        .o_coord_u   (o_coord_u),
        .o_coord_v   (o_coord_v)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one coordinate as an exact fraction n/d
    function automatic void face_coord(input longint m, input longint a, input longint s,
                                       output longint n, output longint d);
        longint am;
        am = (m < 0) ? -m : m;
        if (a <= am) begin
            n = (m > 0) ? s : -s;
            d = 1;
        end else begin
            n = s * m;
            d = a;
        end
    endfunction

    // fraction in [-1,1] to unsigned Q1.15
    function automatic logic [CoordW-1:0] frac_to_q(input longint n, input longint d);
        longint q;
        q = ((n + d) <<< FracBits) / (2 * d);
        if (q > (longint'(1) <<< FracBits))
            q = longint'(1) <<< FracBits;
        return q[CoordW-1:0];
    endfunction

    // expected face and coordinates for one direction
    function automatic t_coord_result predict_coords(input logic signed [CompBits-1:0] x,
            input logic signed [CompBits-1:0] y, input logic signed [CompBits-1:0] z,
            input logic autosel, input logic [2:0] sel);
        t_coord_result   r;
        longint          c[3];
        longint          ab[3];
        int              mj_ax, u_ax, v_ax;
        longint          u_sg, v_sg, a, mj, nu, du, nv, dv, anu, anv;
        cfsc_pkg::t_face f;
        bit              opposite;
        c[0] = x;
        c[1] = y;
        c[2] = z;
        for (int i = 0; i < 3; i++) ab[i] = (c[i] < 0) ? -c[i] : c[i];
        f = sel;
        if (autosel || sel > cfsc_pkg::FACE_NZ) begin
            if (ab[0] > ab[1] && ab[0] > ab[2])
                f = (c[0] > 0) ? cfsc_pkg::FACE_PX : cfsc_pkg::FACE_NX;
            else if (ab[1] > ab[0] && ab[1] > ab[2])
                f = (c[1] > 0) ? cfsc_pkg::FACE_PY : cfsc_pkg::FACE_NY;
            else
                f = (c[2] > 0) ? cfsc_pkg::FACE_PZ : cfsc_pkg::FACE_NZ;
        end
        // per-face axes and signs
        case (f)
            cfsc_pkg::FACE_PX: begin
                mj_ax = 0; u_ax = 2; v_ax = 1; u_sg = -1; v_sg = -1;
            end
            cfsc_pkg::FACE_NX: begin
                mj_ax = 0; u_ax = 2; v_ax = 1; u_sg = 1;  v_sg = -1;
            end
            cfsc_pkg::FACE_PY: begin
                mj_ax = 1; u_ax = 0; v_ax = 2; u_sg = 1;  v_sg = 1;
            end
            cfsc_pkg::FACE_NY: begin
                mj_ax = 1; u_ax = 0; v_ax = 2; u_sg = 1;  v_sg = -1;
            end
            cfsc_pkg::FACE_PZ: begin
                mj_ax = 2; u_ax = 0; v_ax = 1; u_sg = 1;  v_sg = -1;
            end
            default: begin
                mj_ax = 2; u_ax = 0; v_ax = 1; u_sg = -1; v_sg = -1;
            end
        endcase
        a  = ab[mj_ax];
        mj = c[mj_ax];
        face_coord(c[u_ax], a, u_sg, nu, du);
        face_coord(c[v_ax], a, v_sg, nv, dv);
        // direction on the far side snaps the larger coordinate to the edge
        opposite = (f[0] == 1'b0) ? (mj < 0) : (mj > 0);
        if (opposite && a > ab[u_ax] && a > ab[v_ax]) begin
            anu = (nu < 0) ? -nu : nu;
            anv = (nv < 0) ? -nv : nv;
            if (anu * dv > anv * du) begin
                nu = (nu > 0) ? 1 : -1;
                du = 1;
            end else begin
                nv = (nv > 0) ? 1 : -1;
                dv = 1;
            end
        end
        r.face = f;
        r.u    = frac_to_q(nu, du);
        r.v    = frac_to_q(nv, dv);
        return r;
    endfunction

    // send one transaction, idling first at random
    task automatic send_direction(input logic signed [CompBits-1:0] x,
            input logic signed [CompBits-1:0] y, input logic signed [CompBits-1:0] z,
            input logic autosel, input logic [2:0] sel);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_vec_x     <= x;
        i_vec_y     <= y;
        i_vec_z     <= z;
        i_face_auto <= autosel;
        i_face_sel  <= sel;
        pending_coords.push_back(predict_coords(x, y, z, autosel, sel));
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_coord_result exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_coords.size() == 0) begin
                $error("unexpected result face=%0d u=%0d v=%0d", o_face, o_coord_u, o_coord_v);
                n_errors++;
            end else begin
                exp_r = pending_coords.pop_front();
                if (o_face !== exp_r.face) begin
                    $error("face: expected %0d, got %0d", exp_r.face, o_face);
                    n_errors++;
                end
                if (o_coord_u !== exp_r.u) begin
                    $error("coord_u: expected %0d, got %0d", exp_r.u, o_coord_u);
                    n_errors++;
                end
                if (o_coord_v !== exp_r.v) begin
                    $error("coord_v: expected %0d, got %0d", exp_r.v, o_coord_v);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction or result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("cube_face_select_and_coords_tb failed");
            $finish;
        end
    end

    // extremes, every requested face, ties, zero vector, invalid selects
    task automatic test_directed();
        send_direction(16'sh7fff, 16'sh0000, 16'sh0000, 1'b1, 3'd0);
        send_direction(-16'sh8000, 16'sh7fff, -16'sh8000, 1'b1, 3'd0);
        send_direction(16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 3'd0);
        send_direction(16'sh0100, 16'sh0100, 16'sh0050, 1'b1, 3'd0);
        send_direction(16'sh0100, -16'sh0100, 16'sh0100, 1'b1, 3'd0);
        send_direction(-16'sh8000, -16'sh8000, -16'sh8000, 1'b1, 3'd0);
        send_direction(16'sh0010, -16'sh0020, 16'sh0005, 1'b1, 3'd0);
        for (int f = 0; f < 8; f++) begin
            send_direction(16'sh1234, -16'sh0567, 16'sh0abc, 1'b0, f[2:0]);
            send_direction(-16'sh7000, 16'sh0300, -16'sh0400, 1'b0, f[2:0]);
        end
        send_direction(16'sh7fff, 16'sh7fff, -16'sh8000, 1'b0, cfsc_pkg::FACE_NX);
        send_direction(16'sh0000, 16'sh0000, 16'sh0000, 1'b0, cfsc_pkg::FACE_PY);
    endtask

    function automatic logic signed [CompBits-1:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return CompBits'($urandom_range(8)) - 16'sd4;
            default: return CompBits'($urandom);
        endcase
    endfunction

    // random directions, with ties and opposite-face requests mixed in
    task automatic test_random(input int n_items);
        logic signed [CompBits-1:0] x, y, z;
        for (int i = 0; i < n_items; i++) begin
            x = rand_comp();
            y = ($urandom_range(4) == 0) ? x : rand_comp();
            z = ($urandom_range(4) == 0) ? -y : rand_comp();
            send_direction(x, y, z, 1'($urandom), 3'($urandom));
        end
    endtask

    initial begin
        int wait_cycles;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        idle_pct = 0;
        test_random(150);
        idle_pct = 88;
        test_random(150);
        idle_pct = 23;
        test_random(150);
        idle_pct = 0;
        test_random(150);
        start <= 1'b0;
        // drain
        wait_cycles = 0;
        while (pending_coords.size() != 0 && wait_cycles < WatchLimit) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (Latency + 4) @(posedge i_clk);
        if (n_errors == 0 && pending_coords.size() == 0) begin
            $display("cube_face_select_and_coords_tb passed");
        end else begin
            $display("cube_face_select_and_coords_tb failed");
        end
        $finish;
    end
endmodule
